// ===== rtl/acl_pkg.sv =====
package acl_pkg;

   typedef enum logic [2:0] {
      ET_OWNER       = 3'd0,
      ET_GROUP       = 3'd1,
      ET_EVERYONE    = 3'd2,
      ET_USER        = 3'd3,
      ET_NAMED_GROUP = 3'd4
   } entry_type_type;

   // Bit positions in the header's ACL flags and caller flags.
   localparam int AF_MASKED  = 0;
   localparam int AF_WT      = 1;
   localparam int CF_OWNER   = 0;
   localparam int CF_INGROUP = 1;

   // Index of each mask word carried through the queue.
   localparam int QM_MASK  = 0;
   localparam int QM_OWNER = 1;
   localparam int QM_GROUP = 2;
   localparam int QM_OTHER = 3;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   // Control part of a classified item as it travels from front to back.
   typedef struct packed {
      logic       header;
      logic       last;
      logic       apply;
      logic       cls;
      logic       deny;
      logic [1:0] acl_flags;
      logic [1:0] caller_flags;
   } item_ctl_type;

endpackage

// ===== rtl/acl_permission_check.sv =====
// Access check for an NFSv4-style ACL, evaluated one item at a time.
// A request enters on the req_ channel as a header item (req_kind low) that
// carries the requested mask, the ACL flags, the caller's status and the three
// file masks, followed by the ACL's entries (req_kind high) in order. The item
// with req_last_item set closes the request and produces exactly one item on
// the rsp_ channel: rsp_access_denied is high when any requested bit is denied.
// Both channels use valid/ready and transfer when both are high.
// The front classifies entries against the caller's status and pushes them
// into a two-entry queue; the back evaluates them against the running state.
// One item is accepted per cycle while the queue is not full; the last item
// passes through the queue and then the output register before rsp_valid rises.
// When the receiver stalls, the result holds in the output register, the
// back stops draining the queue, and req_ready drops once the queue is full.
// Reset clears the queue, the response valid flag and the evaluation state, so
// entries that arrive before any header are judged against an empty request.
module acl_permission_check
   import acl_pkg::*;
#(
   parameter int MASK_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_kind,
   input  logic [MASK_BITS-1:0] req_mask_bits,
   input  logic [1:0]           req_acl_flags,
   input  logic [1:0]           req_caller_flags,
   input  logic [MASK_BITS-1:0] req_owner_file_mask,
   input  logic [MASK_BITS-1:0] req_group_file_mask,
   input  logic [MASK_BITS-1:0] req_other_file_mask,
   input  logic [2:0]           req_entry_type,
   input  logic                 req_inherit_only,
   input  logic                 req_deny_entry,
   input  logic                 req_id_match,
   input  logic                 req_last_item,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_access_denied
);

   logic                      push;
   logic                      full;
   item_ctl_type              push_ctl;
   logic [3:0][MASK_BITS-1:0] push_masks;
   logic                      pop;
   logic                      pop_valid;
   item_ctl_type              pop_ctl;
   logic [3:0][MASK_BITS-1:0] pop_masks;

   acl_front #(.MASK_BITS(MASK_BITS)) u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_kind),
      .req_mask_bits       (req_mask_bits),
      .req_acl_flags       (req_acl_flags),
      .req_caller_flags    (req_caller_flags),
      .req_owner_file_mask (req_owner_file_mask),
      .req_group_file_mask (req_group_file_mask),
      .req_other_file_mask (req_other_file_mask),
      .req_entry_type      (req_entry_type),
      .req_inherit_only    (req_inherit_only),
      .req_deny_entry      (req_deny_entry),
      .req_id_match        (req_id_match),
      .req_last_item       (req_last_item),
      .q_full              (full),
      .q_push              (push),
      .q_ctl               (push_ctl),
      .q_masks             (push_masks)
   );

   acl_queue #(.MASK_BITS(MASK_BITS)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ctl   (push_ctl),
      .push_masks (push_masks),
      .full       (full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_ctl    (pop_ctl),
      .pop_masks  (pop_masks)
   );

   acl_back #(.MASK_BITS(MASK_BITS)) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (pop_valid),
      .q_ctl             (pop_ctl),
      .q_masks           (pop_masks),
      .q_pop             (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_access_denied (rsp_access_denied)
   );

endmodule

// ===== rtl/acl_front.sv =====
module acl_front
   import acl_pkg::*;
#(
   parameter int MASK_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_kind,
   input  logic [MASK_BITS-1:0]      req_mask_bits,
   input  logic [1:0]                req_acl_flags,
   input  logic [1:0]                req_caller_flags,
   input  logic [MASK_BITS-1:0]      req_owner_file_mask,
   input  logic [MASK_BITS-1:0]      req_group_file_mask,
   input  logic [MASK_BITS-1:0]      req_other_file_mask,
   input  logic [2:0]                req_entry_type,
   input  logic                      req_inherit_only,
   input  logic                      req_deny_entry,
   input  logic                      req_id_match,
   input  logic                      req_last_item,
   input  logic                      q_full,
   output logic                      q_push,
   output item_ctl_type              q_ctl,
   output logic [3:0][MASK_BITS-1:0] q_masks
);

   logic                 owner_ff, owner_in;
   logic                 ingroup_ff, ingroup_in;
   logic                 masked_ff, masked_in;
   logic [MASK_BITS-1:0] gmask_ff, gmask_in;

   logic grp_path;
   logic cls;
   logic apply;

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   // The front keeps its own copy of the header's caller status so that
   // entries can be classified before they reach the back.
   always_comb begin
      apply    = !req_inherit_only;
      cls      = 1'b0;
      grp_path = 1'b0;
      case (entry_type_type'(req_entry_type))
         ET_OWNER: begin
            if (!owner_ff) apply = 1'b0;
            cls = 1'b1;
         end
         ET_GROUP: begin
            if (!ingroup_ff) apply = 1'b0;
            grp_path = 1'b1;
         end
         ET_USER: begin
            if (!req_id_match) apply = 1'b0;
            if (owner_ff) cls = 1'b1;
            else grp_path = 1'b1;
         end
         ET_NAMED_GROUP: begin
            if (!req_id_match) apply = 1'b0;
            grp_path = 1'b1;
         end
         default: begin
         end
      endcase
      if (grp_path) cls = 1'b1;

      q_ctl.header       = !req_kind;
      q_ctl.last         = req_last_item;
      q_ctl.apply        = apply;
      q_ctl.cls          = cls;
      q_ctl.deny         = req_deny_entry;
      q_ctl.acl_flags    = req_acl_flags;
      q_ctl.caller_flags = req_caller_flags;

      q_masks[QM_MASK]  = req_mask_bits;
      if (req_kind && grp_path && masked_ff && !req_deny_entry) begin
         q_masks[QM_MASK] = req_mask_bits & gmask_ff;
      end
      q_masks[QM_OWNER] = req_owner_file_mask;
      q_masks[QM_GROUP] = req_group_file_mask;
      q_masks[QM_OTHER] = req_other_file_mask;
   end

   always_comb begin
      owner_in   = owner_ff;
      ingroup_in = ingroup_ff;
      masked_in  = masked_ff;
      gmask_in   = gmask_ff;
      if (q_push && !req_kind) begin
         owner_in   = req_caller_flags[CF_OWNER];
         ingroup_in = req_caller_flags[CF_INGROUP];
         masked_in  = req_acl_flags[AF_MASKED];
         gmask_in   = req_group_file_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owner_ff   <= 1'b0;
         ingroup_ff <= 1'b0;
         masked_ff  <= 1'b0;
         gmask_ff   <= '0;
      end else begin
         owner_ff   <= owner_in;
         ingroup_ff <= ingroup_in;
         masked_ff  <= masked_in;
         gmask_ff   <= gmask_in;
      end
   end

endmodule

// ===== rtl/acl_queue.sv =====
module acl_queue
   import acl_pkg::*;
#(
   parameter int MASK_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  item_ctl_type              push_ctl,
   input  logic [3:0][MASK_BITS-1:0] push_masks,
   output logic                      full,
   input  logic                      pop,
   output logic                      pop_valid,
   output item_ctl_type              pop_ctl,
   output logic [3:0][MASK_BITS-1:0] pop_masks
);

   item_ctl_type              ctl_mem_ff   [QUEUE_DEPTH];
   logic [3:0][MASK_BITS-1:0] masks_mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]         count_ff, count_in;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_ctl   = ctl_mem_ff[rd_ptr_ff];
   assign pop_masks = masks_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = rd_ptr_ff + 1'b1;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ctl_mem_ff[wr_ptr_ff]   <= push_ctl;
         masks_mem_ff[wr_ptr_ff] <= push_masks;
      end
   end

endmodule

// ===== rtl/acl_back.sv =====
module acl_back
   import acl_pkg::*;
#(
   parameter int MASK_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_valid,
   input  item_ctl_type              q_ctl,
   input  logic [3:0][MASK_BITS-1:0] q_masks,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_access_denied
);

   logic [MASK_BITS-1:0]      req_ff, req_in;
   logic [MASK_BITS-1:0]      undec_ff, undec_in;
   logic [MASK_BITS-1:0]      den_ff, den_in;
   logic [2:0][MASK_BITS-1:0] fm_ff, fm_in;
   logic [1:0]                af_ff, af_in;
   logic [1:0]                cf_ff, cf_in;
   logic                      cls_ff, cls_in;
   logic                      fin_ff, fin_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_denied_ff, rsp_denied_in;
   logic [MASK_BITS-1:0]      final_bits;

   assign q_pop             = q_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_access_denied = rsp_denied_ff;

   always_comb begin
      req_in   = req_ff;
      undec_in = undec_ff;
      den_in   = den_ff;
      fm_in    = fm_ff;
      af_in    = af_ff;
      cf_in    = cf_ff;
      cls_in   = cls_ff;
      fin_in   = fin_ff;
      if (q_pop) begin
         if (q_ctl.header) begin
            req_in   = q_masks[QM_MASK];
            undec_in = q_masks[QM_MASK];
            den_in   = '0;
            fm_in    = q_masks[QM_OTHER:QM_OWNER];
            af_in    = q_ctl.acl_flags;
            cf_in    = q_ctl.caller_flags;
            cls_in   = q_ctl.caller_flags[CF_INGROUP] || !q_ctl.acl_flags[AF_MASKED];
            // A masked write-through ACL with an owning caller ignores entries.
            fin_in   = q_ctl.acl_flags[AF_MASKED] && q_ctl.acl_flags[AF_WT]
                       && q_ctl.caller_flags[CF_OWNER];
         end else if (!fin_ff && q_ctl.apply) begin
            cls_in = cls_ff | q_ctl.cls;
            if (q_ctl.deny) den_in = den_ff | (q_masks[QM_MASK] & undec_ff);
            undec_in = undec_ff & ~q_masks[QM_MASK];
            if (undec_in == '0 && cls_in) fin_in = 1'b1;
         end
         if (q_ctl.last) fin_in = 1'b1;
      end
   end

   // For a masked ACL, apply the file mask of the caller's class to the evaluated bits.
   always_comb begin
      if (af_in[AF_MASKED] && af_in[AF_WT] && cf_in[CF_OWNER]) begin
         final_bits = req_in & ~fm_in[0];
      end else begin
         final_bits = den_in | undec_in;
         if (af_in[AF_MASKED]) begin
            if (cf_in[CF_OWNER]) final_bits = final_bits | (req_in & ~fm_in[0]);
            else if (cls_in) final_bits = final_bits | (req_in & ~fm_in[1]);
            else if (af_in[AF_WT]) final_bits = req_in & ~fm_in[2];
            else final_bits = final_bits | (req_in & ~fm_in[2]);
         end
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_denied_in = rsp_denied_ff;
      if (q_pop && q_ctl.last) begin
         rsp_valid_in  = 1'b1;
         rsp_denied_in = |final_bits;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_ff       <= '0;
         undec_ff     <= '0;
         den_ff       <= '0;
         fm_ff        <= '0;
         af_ff        <= '0;
         cf_ff        <= '0;
         cls_ff       <= 1'b0;
         fin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_ff       <= req_in;
         undec_ff     <= undec_in;
         den_ff       <= den_in;
         fm_ff        <= fm_in;
         af_ff        <= af_in;
         cf_ff        <= cf_in;
         cls_ff       <= cls_in;
         fin_ff       <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_denied_ff <= rsp_denied_in;
   end

   a_undecided_within_requested: assert property (@(posedge clock) disable iff (reset)
      (undec_ff & ~req_ff) == '0)
      else $error("undecided bits outside the requested mask");

   a_last_finishes: assert property (@(posedge clock) disable iff (reset)
      q_pop && q_ctl.last |=> fin_ff && rsp_valid_ff)
      else $error("last item did not finish the request");

   a_wt_owner_finished: assert property (@(posedge clock) disable iff (reset)
      q_pop && q_ctl.header && q_ctl.acl_flags[AF_MASKED] && q_ctl.acl_flags[AF_WT]
      && q_ctl.caller_flags[CF_OWNER] |=> fin_ff)
      else $error("write-through owner request not marked finished");

   a_denied_within_requested: assert property (@(posedge clock) disable iff (reset)
      (den_ff & ~req_ff) == '0)
      else $error("denied bits outside the requested mask");

endmodule
